// ===== sv/assert_macros.svh =====
// shared concurrent assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// check on every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check on every clock edge, reset included
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== sv/bvap_pkg.sv =====
package bvap_pkg;

    localparam int SAMPLE_DEPTH = 8;
    localparam int PTR_W        = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
    localparam int CNT_W        = $clog2(SAMPLE_DEPTH + 1);
    localparam int MV_W         = 16;
    localparam int SUM_W        = MV_W + CNT_W;
    localparam int DIV_CYC_W    = $clog2(SUM_W + 1);

    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;

    // register map, word addressed by paddr[3:2]
    typedef enum logic [1:0] {
        REG_INTERVAL = 2'd0,
        REG_MIN_MV   = 2'd1,
        REG_MAX_MV   = 2'd2,
        REG_RATIO    = 2'd3
    } t_reg_idx;

    localparam logic [15:0] RST_INTERVAL = 16'd1000;
    localparam logic [15:0] RST_MIN_MV   = 16'd3000;
    localparam logic [15:0] RST_MAX_MV   = 16'd4500;
    localparam logic [15:0] RST_RATIO    = 16'd8192;

    localparam logic signed [7:0] PCT_INVALID = -8'sd1;

    // q4.12 scaling
    localparam int          SCALE_W     = 28;
    localparam int          SCALE_SH    = 12;
    localparam logic [27:0] SCALE_ROUND = 28'd2048;

    // state of charge curve, all segments span the same number of mv
    localparam int CURVE_POINTS = 9;
    localparam int SEG_W        = $clog2(CURVE_POINTS);
    localparam int PCT_W        = 7;
    localparam int CURVE_OFF_W  = 7;
    localparam int CURVE_X_W    = 11;
    localparam logic [15:0] CURVE_MV [CURVE_POINTS] = '{
        16'd3400, 16'd3500, 16'd3600, 16'd3700, 16'd3800,
        16'd3900, 16'd4000, 16'd4100, 16'd4200
    };
    localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
        7'd0, 7'd5, 7'd15, 7'd30, 7'd45, 7'd60, 7'd75, 7'd90, 7'd100
    };
    localparam int CURVE_SPAN = 100;
    localparam logic [CURVE_X_W-1:0] CURVE_HALF = CURVE_X_W'(CURVE_SPAN / 2);
    // x / 100 == (x * 5243) >> 19 for every x below 1600
    localparam int RECIP_W  = 13;
    localparam int RECIP_SH = 19;
    localparam logic [RECIP_W-1:0] CURVE_RECIP = 13'd5243;
    localparam int Q_W      = CURVE_X_W + RECIP_W - RECIP_SH;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_CHECK,
        S_SUM,
        S_DIV,
        S_CURVE,
        S_MAP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== sv/battery_voltage_average_to_percent.sv =====
// Battery voltage averager. Each input item (timestamp, converter reading) gives exactly one
// result item. An item that arrives before the sample interval has passed reports sampled = 0
// with the current average. A sampled reading is scaled by the q4.12 divider ratio; out of the
// valid window it clears the average, in the window it is written to an 8-entry ring memory and
// the filled entries are re-summed, one memory word per cycle, then divided by the fill count in
// a bit-serial divider, one quotient bit per cycle, and mapped to percent through the curve. The
// ring needs no clearing after reset; only written entries are ever summed. Configuration is
// written through the apb port; the user must write it only while the block is idle, as the
// block itself does not enforce this.
`include "assert_macros.svh"

module battery_voltage_average_to_percent (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [31:0]                   i_now_ms,
    input  logic [11:0]                   i_adc_mv,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_sampled,
    output logic                          o_valid_res,
    output logic [15:0]                   o_filtered_mv,
    output logic signed [7:0]             o_percent,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bvap_pkg::PADDR_W-1:0]  paddr,
    input  logic [bvap_pkg::PDATA_W-1:0]  pwdata,
    output logic [bvap_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import bvap_pkg::*;

    // configuration
    logic [15:0] r_interval, r_min_mv, r_max_mv, r_ratio;

    // block state
    t_state            r_state, n_state;
    logic [31:0]       r_last, n_last;
    logic [PTR_W-1:0]  r_wp, n_wp;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic              r_valid, n_valid;
    logic [MV_W-1:0]   r_avg, n_avg;
    logic signed [7:0] r_pct, n_pct;

    // per item work registers
    logic [11:0]          r_adc, n_adc;
    logic                 r_take, n_take;
    logic [MV_W-1:0]      r_mv, n_mv;
    logic [SUM_W-1:0]     r_sum, n_sum;
    logic [CNT_W-1:0]     r_rd_idx, n_rd_idx;
    logic                 r_rd_pend, n_rd_pend;
    logic [MV_W-1:0]      r_avg_new, n_avg_new;
    logic [CURVE_X_W-1:0] r_cx, n_cx;
    logic [PCT_W-1:0]     r_cbase, n_cbase;

    // output register
    logic              r_out_valid, n_out_valid;
    logic              r_o_sampled, n_o_sampled;
    logic              r_o_valid_res, n_o_valid_res;
    logic [MV_W-1:0]   r_o_filtered, n_o_filtered;
    logic signed [7:0] r_o_percent, n_o_percent;

    // ring memory
    logic [MV_W-1:0]  r_ring [SAMPLE_DEPTH];
    logic [MV_W-1:0]  r_rd_data;
    logic             mem_we, mem_re;
    logic [PTR_W-1:0] mem_wa, mem_ra;

    // divider
    logic                 div_start;
    logic [SUM_W-1:0]     div_quo;
    t_div_stat            div_stat;

    logic                 in_acc, take_now, out_free;
    logic [31:0]          elapsed;
    logic [SCALE_W-1:0]   scale_full;
    logic                 in_window;
    logic [SEG_W-1:0]     seg;
    logic [15:0]          seg_off;
    logic [CURVE_X_W-1:0] seg_rise;
    logic [CURVE_X_W-1:0] seg_x;
    logic [RECIP_W+CURVE_X_W-1:0] recip_prod;
    logic [Q_W-1:0]       seg_q;

    logic                 idle_fill_ok, invalid_res_ok;

    bvap_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_fill),
        .o_quotient (div_quo),
        .o_stat     (div_stat)
    );

    // apb configuration port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= RST_INTERVAL;
            r_min_mv   <= RST_MIN_MV;
            r_max_mv   <= RST_MAX_MV;
            r_ratio    <= RST_RATIO;
        end else if (psel && penable && pwrite && pready) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_INTERVAL: r_interval <= pwdata[15:0];
                REG_MIN_MV:   r_min_mv   <= pwdata[15:0];
                REG_MAX_MV:   r_max_mv   <= pwdata[15:0];
                REG_RATIO:    r_ratio    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_INTERVAL: prdata = {16'b0, r_interval};
            REG_MIN_MV:   prdata = {16'b0, r_min_mv};
            REG_MAX_MV:   prdata = {16'b0, r_max_mv};
            REG_RATIO:    prdata = {16'b0, r_ratio};
            default:      prdata = '0;
        endcase
    end

    // datapath terms
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign elapsed    = i_now_ms - r_last;
    assign take_now   = (r_last == 32'd0) || (elapsed >= {16'b0, r_interval});
    assign out_free   = !r_out_valid || !i_out_stall;
    assign scale_full = ({16'b0, r_adc} * {12'b0, r_ratio}) + SCALE_ROUND;
    assign in_window  = (r_mv >= r_min_mv) && (r_mv <= r_max_mv);

    // curve segment: lowest breakpoint at or above the average
    always_comb begin
        seg = SEG_W'(1);
        for (int k = CURVE_POINTS - 1; k >= 1; k--) begin
            if (r_avg_new <= CURVE_MV[k]) begin
                seg = SEG_W'(k);
            end
        end
        seg_off  = r_avg_new - CURVE_MV[seg - SEG_W'(1)];
        seg_rise = CURVE_X_W'(CURVE_PCT[seg] - CURVE_PCT[seg - SEG_W'(1)]);
        seg_x    = CURVE_X_W'(seg_off[CURVE_OFF_W-1:0]) * seg_rise + CURVE_HALF;
    end

    assign recip_prod = {{RECIP_W{1'b0}}, r_cx} * {{CURVE_X_W{1'b0}}, CURVE_RECIP};
    assign seg_q      = recip_prod[RECIP_W+CURVE_X_W-1:RECIP_SH];

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_last        = r_last;
        n_wp          = r_wp;
        n_fill        = r_fill;
        n_valid       = r_valid;
        n_avg         = r_avg;
        n_pct         = r_pct;
        n_adc         = r_adc;
        n_take        = r_take;
        n_mv          = r_mv;
        n_sum         = r_sum;
        n_rd_idx      = r_rd_idx;
        n_rd_pend     = 1'b0;
        n_avg_new     = r_avg_new;
        n_cx          = r_cx;
        n_cbase       = r_cbase;
        n_out_valid   = r_out_valid && i_out_stall;
        n_o_sampled   = r_o_sampled;
        n_o_valid_res = r_o_valid_res;
        n_o_filtered  = r_o_filtered;
        n_o_percent   = r_o_percent;
        mem_we        = 1'b0;
        mem_wa        = r_wp;
        mem_re        = 1'b0;
        mem_ra        = r_rd_idx[PTR_W-1:0];
        div_start     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_adc  = i_adc_mv;
                    n_take = take_now;
                    if (take_now) begin
                        n_last  = i_now_ms;
                        n_state = S_SCALE;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCALE: begin
                n_mv    = scale_full[SCALE_SH+MV_W-1:SCALE_SH];
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (in_window) begin
                    mem_we   = 1'b1;
                    n_wp     = (r_wp == PTR_W'(SAMPLE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                    n_fill   = (r_fill == CNT_W'(SAMPLE_DEPTH)) ? r_fill : r_fill + 1'b1;
                    n_sum    = '0;
                    n_rd_idx = '0;
                    n_state  = S_SUM;
                end else begin
                    n_valid = 1'b0;
                    n_avg   = '0;
                    n_pct   = PCT_INVALID;
                    n_fill  = '0;
                    n_wp    = '0;
                    n_state = S_DONE;
                end
            end
            S_SUM: begin
                // one ring word per cycle, the read data is registered and summed when it arrives
                mem_re = (r_rd_idx < r_fill);
                if (mem_re) begin
                    n_rd_idx  = r_rd_idx + 1'b1;
                    n_rd_pend = 1'b1;
                end
                if (r_rd_pend) begin
                    n_sum = r_sum + {{(SUM_W-MV_W){1'b0}}, r_rd_data};
                end
                if (!mem_re && !r_rd_pend) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    n_avg_new = div_quo[MV_W-1:0];
                    n_state   = S_CURVE;
                end
            end
            S_CURVE: begin
                if (r_avg_new <= CURVE_MV[0]) begin
                    n_cbase = CURVE_PCT[0];
                    n_cx    = '0;
                end else if (r_avg_new >= CURVE_MV[CURVE_POINTS-1]) begin
                    n_cbase = CURVE_PCT[CURVE_POINTS-1];
                    n_cx    = '0;
                end else begin
                    n_cbase = CURVE_PCT[seg - SEG_W'(1)];
                    n_cx    = seg_x;
                end
                n_state = S_MAP;
            end
            S_MAP: begin
                n_avg   = r_avg_new;
                n_pct   = signed'({1'b0, r_cbase + PCT_W'(seg_q)});
                n_valid = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_o_sampled   = r_take;
                    n_o_valid_res = r_valid;
                    n_o_filtered  = r_avg;
                    n_o_percent   = r_pct;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= '0;
            r_wp        <= '0;
            r_fill      <= '0;
            r_valid     <= 1'b0;
            r_avg       <= '0;
            r_pct       <= PCT_INVALID;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last      <= n_last;
            r_wp        <= n_wp;
            r_fill      <= n_fill;
            r_valid     <= n_valid;
            r_avg       <= n_avg;
            r_pct       <= n_pct;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
        r_adc         <= n_adc;
        r_take        <= n_take;
        r_mv          <= n_mv;
        r_sum         <= n_sum;
        r_rd_idx      <= n_rd_idx;
        r_avg_new     <= n_avg_new;
        r_cx          <= n_cx;
        r_cbase       <= n_cbase;
        r_o_sampled   <= n_o_sampled;
        r_o_valid_res <= n_o_valid_res;
        r_o_filtered  <= n_o_filtered;
        r_o_percent   <= n_o_percent;
    end

    // ring memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_ring[mem_wa] <= r_mv;
        end
        if (mem_re) begin
            r_rd_data <= r_ring[mem_ra];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_sampled     = r_o_sampled;
    assign o_valid_res   = r_o_valid_res;
    assign o_filtered_mv = r_o_filtered;
    assign o_percent     = r_o_percent;

    // terms checked below
    assign idle_fill_ok   = (r_state != S_IDLE) || (r_valid == (r_fill != '0));
    assign invalid_res_ok = !o_out_valid || o_valid_res ||
                            (o_percent == PCT_INVALID && o_filtered_mv == '0);

    `ASSERT_CLK(a_no_rw_overlap, i_clk, i_rst_n, !(mem_we && mem_re), "ring read and write overlap")
    `ASSERT_CLK(a_fill_range, i_clk, i_rst_n, r_fill <= CNT_W'(SAMPLE_DEPTH), "fill count overflow")
    `ASSERT_CLK(a_idle_valid_fill, i_clk, i_rst_n, idle_fill_ok, "valid flag and fill disagree")
    `ASSERT_CLK(a_invalid_result, i_clk, i_rst_n, invalid_res_ok, "invalid result with data")

endmodule

// ===== sv/bvap_div.sv =====
`include "assert_macros.svh"

module bvap_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [bvap_pkg::SUM_W-1:0]  i_dividend,
    input  logic [bvap_pkg::CNT_W-1:0]  i_divisor,
    output logic [bvap_pkg::SUM_W-1:0]  o_quotient,
    output bvap_pkg::t_div_stat         o_stat
);
    import bvap_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CYC_W-1:0] r_cnt, n_cnt;
    logic [SUM_W-1:0]     r_quo, n_quo;
    logic [CNT_W-1:0]     r_rem, n_rem;
    logic [CNT_W-1:0]     r_dvs, n_dvs;

    logic [CNT_W:0]       rem_sh;
    logic [CNT_W:0]       rem_sub;
    logic                 ge;

    // restoring division, one quotient bit per cycle
    always_comb begin
        rem_sh  = {r_rem, r_quo[SUM_W-1]};
        ge      = rem_sh >= {1'b0, r_dvs};
        rem_sub = rem_sh - {1'b0, r_dvs};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_CYC_W'(SUM_W);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[SUM_W-2:0], ge};
            n_rem = ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == DIV_CYC_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_quotient  = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

    `ASSERT_CLK(a_start_idle, i_clk, i_rst_n, i_start |-> !r_busy, "divider restarted while busy")
    `ASSERT_CLK(a_done_idle, i_clk, i_rst_n, r_done |-> !r_busy, "divider done while busy")
    `ASSERT_CLK(a_idle_count, i_clk, i_rst_n, !r_busy |-> (r_cnt == '0), "divider count left over")

endmodule

// ===== tb/bvap_soc_checker.sv =====
`timescale 1ns / 100ps

module bvap_soc_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [31:0]                   i_now_ms,
    input  logic [11:0]                   i_adc_mv,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic                          i_sampled,
    input  logic                          i_valid_res,
    input  logic [15:0]                   i_filtered_mv,
    input  logic signed [7:0]             i_percent,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [bvap_pkg::PADDR_W-1:0]  i_paddr,
    input  logic [bvap_pkg::PDATA_W-1:0]  i_pwdata,
    input  logic                          i_pready,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_checked
);
    import bvap_pkg::*;

    localparam int KNEES     = 9;
    localparam int unsigned KNEE_MV [KNEES] = '{
        3400, 3500, 3600, 3700, 3800, 3900, 4000, 4100, 4200
    };
    localparam int unsigned KNEE_PCT [KNEES] = '{
        0, 5, 15, 30, 45, 60, 75, 90, 100
    };

    typedef struct packed {
        logic              sampled;
        logic              valid_res;
        logic [15:0]       filtered_mv;
        logic signed [7:0] percent;
    } t_soc_result;

    t_soc_result soc_expected_q[$];
    t_soc_result want;

    // register shadows
    logic [15:0] interval_ms;
    logic [15:0] window_lo_mv;
    logic [15:0] window_hi_mv;
    logic [15:0] ratio_q12;

    // averager state
    logic [31:0]             last_take_ms;
    logic [15:0]             mv_ring [SAMPLE_DEPTH];
    logic [PTR_W-1:0]        ring_wr;
    logic [CNT_W-1:0]        ring_fill;
    logic                    avg_ok;
    logic [15:0]             avg_mv;
    logic signed [7:0]       soc_pct;

    int fail_cnt = 0;
    int checked_cnt = 0;

    assign o_fail_count = fail_cnt;
    assign o_checked    = checked_cnt;

    task automatic report_mismatch(input string msg);
        fail_cnt++;
        $display("%0t: soc mismatch: %s", $time, msg);
    endtask

    // rounded linear interpolation between the curve knees
    function automatic logic signed [7:0] soc_from_mv(input logic [15:0] mv);
        int unsigned off;
        int unsigned span;
        int unsigned rise;
        logic signed [7:0] pct;
        pct = 8'sd100;
        if (mv <= KNEE_MV[0]) begin
            pct = 8'sd0;
        end else begin
            // walk down so the lowest knee at or above mv wins
            for (int k = KNEES - 1; k >= 1; k--) begin
                if (mv <= KNEE_MV[k]) begin
                    off  = mv - KNEE_MV[k-1];
                    span = KNEE_MV[k] - KNEE_MV[k-1];
                    rise = KNEE_PCT[k] - KNEE_PCT[k-1];
                    pct  = 8'(KNEE_PCT[k-1] + (off * rise + span / 2) / span);
                end
            end
        end
        return pct;
    endfunction

    task automatic predict_reading(input logic [31:0] now, input logic [11:0] adc);
        logic        take;
        logic [31:0] elapsed;
        logic [27:0] scaled;
        logic [15:0] mv;
        int unsigned total;
        elapsed = now - last_take_ms;
        take    = (last_take_ms == 32'd0) || (elapsed >= {16'd0, interval_ms});
        if (take) begin
            last_take_ms = now;
            scaled = 28'(adc) * 28'(ratio_q12) + 28'd2048;
            mv     = scaled[27:12];
            if (mv < window_lo_mv || mv > window_hi_mv) begin
                avg_ok    = 1'b0;
                avg_mv    = '0;
                soc_pct   = PCT_INVALID;
                ring_fill = '0;
                ring_wr   = '0;
            end else begin
                mv_ring[ring_wr] = mv;
                ring_wr = PTR_W'((ring_wr + 1) % SAMPLE_DEPTH);
                if (ring_fill < SAMPLE_DEPTH) begin
                    ring_fill = ring_fill + 1'b1;
                end
                total = 0;
                for (int k = 0; k < ring_fill; k++) begin
                    total += mv_ring[k];
                end
                avg_mv  = 16'(total / ring_fill);
                soc_pct = soc_from_mv(avg_mv);
                avg_ok  = 1'b1;
            end
        end
        soc_expected_q.push_back('{take, avg_ok, avg_mv, soc_pct});
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            interval_ms  = RST_INTERVAL;
            window_lo_mv = RST_MIN_MV;
            window_hi_mv = RST_MAX_MV;
            ratio_q12    = RST_RATIO;
            last_take_ms = '0;
            ring_wr      = '0;
            ring_fill    = '0;
            avg_ok       = 1'b0;
            avg_mv       = '0;
            soc_pct      = PCT_INVALID;
            soc_expected_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[PADDR_W-1:2]))
                    REG_INTERVAL: interval_ms  = i_pwdata[15:0];
                    REG_MIN_MV:   window_lo_mv = i_pwdata[15:0];
                    REG_MAX_MV:   window_hi_mv = i_pwdata[15:0];
                    REG_RATIO:    ratio_q12    = i_pwdata[15:0];
                    default: ;
                endcase
            end
            // the result of an item can never leave on the edge that takes the item
            if (i_out_valid && !i_out_stall) begin
                checked_cnt++;
                if (soc_expected_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none pending",
                                              checked_cnt));
                end else begin
                    want = soc_expected_q.pop_front();
                    if (i_sampled !== want.sampled) begin
                        report_mismatch($sformatf("result %0d sampled: got %0d, want %0d",
                                                  checked_cnt, i_sampled, want.sampled));
                    end
                    if (i_valid_res !== want.valid_res) begin
                        report_mismatch($sformatf("result %0d valid_res: got %0d, want %0d",
                                                  checked_cnt, i_valid_res, want.valid_res));
                    end
                    if (i_filtered_mv !== want.filtered_mv) begin
                        report_mismatch($sformatf("result %0d filtered_mv: got %0d, want %0d",
                                                  checked_cnt, i_filtered_mv, want.filtered_mv));
                    end
                    if (i_percent !== want.percent) begin
                        report_mismatch($sformatf("result %0d percent: got %0d, want %0d",
                                                  checked_cnt, int'(i_percent),
                                                  int'(want.percent)));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_reading(i_now_ms, i_adc_mv);
            end
        end
        o_pending <= soc_expected_q.size();
    end

endmodule

// ===== tb/battery_voltage_average_to_percent_tb.sv =====
`timescale 1ns / 100ps

module battery_voltage_average_to_percent_tb;
    import bvap_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 40;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [31:0]       now_ms   = '0;
    logic [11:0]       adc_mv   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              sampled;
    logic              valid_res;
    logic [15:0]       filtered_mv;
    logic signed [7:0] percent;

    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int fail_count;
    int pending;
    int checked;

    int unsigned cycle_cnt  = 0;
    int unsigned stall_left = 0;
    logic        in_pace    = 1'b1;
    logic        out_pace   = 1'b1;

    // stimulus view of the current register setting
    logic [31:0] clock_ms   = '0;
    logic [15:0] set_interval = RST_INTERVAL;
    logic [15:0] set_min      = RST_MIN_MV;
    logic [15:0] set_max      = RST_MAX_MV;
    logic [15:0] set_ratio    = RST_RATIO;
    int          sent     = 0;
    int          settings = 1;

    always #1 i_clk = ~i_clk;

    battery_voltage_average_to_percent dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_now_ms      (now_ms),
        .i_adc_mv      (adc_mv),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_sampled     (sampled),
        .o_valid_res   (valid_res),
        .o_filtered_mv (filtered_mv),
        .o_percent     (percent),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    bvap_soc_checker soc_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_now_ms      (now_ms),
        .i_adc_mv      (adc_mv),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_sampled     (sampled),
        .i_valid_res   (valid_res),
        .i_filtered_mv (filtered_mv),
        .i_percent     (percent),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    // receiver holds off at random after each result item while out_pace is set
    always @(posedge i_clk) begin : rx_pace
        int unsigned n;
        if (!i_rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (out_stall) begin
            if (stall_left <= 1) begin
                out_stall  <= 1'b0;
                stall_left <= 0;
            end else begin
                stall_left <= stall_left - 1;
            end
        end else if (out_valid) begin
            n = out_pace ? $urandom_range(0, 6) : 0;
            stall_left <= n;
            out_stall  <= (n != 0);
        end
    end

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("battery_voltage_average_to_percent_tb: errors");
        $finish;
    end

    task automatic send_reading(input logic [31:0] t, input logic [11:0] a);
        int unsigned gap;
        gap = in_pace ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        now_ms   <= t;
        adc_mv   <= a;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        sent++;
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(idx));
        pwdata  <= PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // sender goes quiet until every item has its result back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [15:0] iv, input logic [15:0] mn,
                                 input logic [15:0] mx, input logic [15:0] rt);
        wait_for_results();
        write_reg(REG_INTERVAL, iv);
        write_reg(REG_MIN_MV, mn);
        write_reg(REG_MAX_MV, mx);
        write_reg(REG_RATIO, rt);
        set_interval = iv;
        set_min      = mn;
        set_max      = mx;
        set_ratio    = rt;
        settings++;
    endtask

    task automatic set_pace(input logic tx_on, input logic rx_on);
        in_pace  = tx_on;
        out_pace <= rx_on;
    endtask

    task automatic send_random(input int count);
        int unsigned pick;
        int unsigned target;
        int unsigned a;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            a    = $urandom_range(0, 4095);
            if (pick < 70) begin
                // on time, reading aimed into the window or near the curve range
                clock_ms += set_interval + $urandom_range(0, 40);
                if (set_min <= set_max && $urandom_range(0, 1) == 1) begin
                    target = $urandom_range(set_min, set_max);
                end else begin
                    target = $urandom_range(3350, 4250);
                end
                if (set_ratio != 0) begin
                    a = (target * 4096 + set_ratio / 2) / set_ratio;
                end
                if (a > 4095) begin
                    a = 4095;
                end
            end else if (pick < 80) begin
                if (set_interval > 1) begin
                    clock_ms += $urandom_range(0, set_interval - 1);
                end
            end else if (pick < 85) begin
                clock_ms += set_interval;
            end else if (pick < 95) begin
                clock_ms += $urandom();
            end else if (pick < 98) begin
                clock_ms = $urandom();
            end else begin
                clock_ms = '0;
            end
            send_reading(clock_ms, 12'(a));
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setting: interval 1000, window 3000..4500, ratio 2.0
        send_reading(32'd0, 12'd1700);       // first item, taken at time zero
        send_reading(32'd5, 12'd1750);       // last time still zero, taken again
        send_reading(32'd500, 12'd2000);     // too early
        send_reading(32'd1005, 12'd2100);
        send_reading(32'd2005, 12'd0);       // below the window
        send_reading(32'd3005, 12'd4095);    // above the window
        for (int k = 0; k < 9; k++) begin
            // fills the ring and wraps the write position
            send_reading(32'd4005 + 32'd1000 * k, 12'(1700 + 55 * k));
        end
        send_reading(32'hFFFF_FF00, 12'd2000);
        send_reading(32'd256, 12'd2000);     // early across the timer wrap
        send_reading(32'd752, 12'd2000);     // on time across the wrap
        send_reading(32'd1751, 12'd1900);    // one ms short
        send_reading(32'd1752, 12'd1900);    // exactly the interval
        send_reading(32'd2752, 12'd4095);
        send_reading(32'd3752, 12'd2150);    // above the top of the curve
        send_reading(32'd4752, 12'd1);
        send_reading(32'd5752, 12'd1650);    // below the bottom of the curve
        clock_ms = 32'd5752;

        apply_setting(16'd0, 16'd0, 16'd65535, 16'd65535);
        set_pace(1'b1, 1'b1);
        send_random(60);

        apply_setting(16'd65535, 16'd3000, 16'd4500, 16'd8192);
        set_pace(1'b0, 1'b0);
        send_random(60);

        apply_setting(16'd1000, 16'd65535, 16'd0, 16'd8192);
        set_pace(1'b1, 1'b0);
        send_random(40);

        apply_setting(16'd10, 16'd0, 16'd100, 16'd0);
        set_pace(1'b0, 1'b1);
        send_random(40);

        apply_setting(16'd1, 16'd3200, 16'd4400, 16'd4096);
        set_pace(1'b1, 1'b1);
        send_random(80);

        repeat (4) begin
            apply_setting(16'($urandom_range(0, 2000)), 16'($urandom_range(2800, 3500)),
                          16'($urandom_range(4000, 5000)), 16'($urandom_range(4096, 12288)));
            set_pace(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            send_random(70);
        end

        apply_setting(16'd500, 16'd3000, 16'd4500, 16'd8192);
        set_pace(1'b1, 1'b1);
        send_random(60);

        wait_for_results();
        $display("%0d readings sent under %0d register settings, %0d results compared",
                 sent, settings, checked);
        if (fail_count == 0 && pending == 0) begin
            $display("battery_voltage_average_to_percent_tb: clean");
        end else begin
            $display("battery_voltage_average_to_percent_tb: errors");
        end
        $finish;
    end

endmodule
